[rtl/fas_pkg.sv]
// Shared constants and types of the floating-point add/subtract pipeline.
package fas_pkg;

   localparam int FRAC_BITS_DEFAULT = 23;
   localparam int EXP_BITS_DEFAULT  = 8;

   typedef enum logic [1:0] {
      STATUS_NORMAL    = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      logic bypass;
   } align_ctrl_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } norm_ctrl_type;

endpackage

[rtl/fas_align.sv]
// Operand unpacking, exponent compare, alignment shift and significand add.
module fas_align #(
   parameter int FRAC_BITS = fas_pkg::FRAC_BITS_DEFAULT,
   parameter int EXP_BITS  = fas_pkg::EXP_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          stall_out,
   input  logic                          action,
   input  logic [FRAC_BITS-1:0]          frac_a,
   input  logic [EXP_BITS-1:0]           exp_a,
   input  logic [FRAC_BITS-1:0]          frac_b,
   input  logic [EXP_BITS-1:0]           exp_b,
   input  logic                          hold_in,
   output fas_pkg::align_ctrl_type       ctrl_out,
   output logic signed [FRAC_BITS+2:0]   sum_out,
   output logic signed [FRAC_BITS+1:0]   large_out,
   output logic [EXP_BITS-1:0]           exp_out
);

   localparam int SUM_W = FRAC_BITS + 3;

   logic                    s1_en;
   logic                    s2_en;
   logic                    s1_valid_ff;
   logic                    s2_valid_ff;

   logic signed [SUM_W-1:0] sig_a_in;
   logic signed [SUM_W-1:0] pos_b;
   logic signed [SUM_W-1:0] sig_b_in;
   logic                    a_small_in;
   logic [EXP_BITS-1:0]     diff_in;
   logic [EXP_BITS-1:0]     big_exp_in;

   logic signed [SUM_W-1:0] s1_sig_a_ff;
   logic signed [SUM_W-1:0] s1_sig_b_ff;
   logic                    s1_a_small_ff;
   logic [EXP_BITS-1:0]     s1_diff_ff;
   logic [EXP_BITS-1:0]     s1_big_exp_ff;

   logic signed [SUM_W-1:0] small_sig;
   logic signed [SUM_W-1:0] large_sig;
   logic signed [SUM_W-1:0] shifted_sig;
   logic                    bypass_in;
   logic signed [SUM_W-1:0] sum_in;

   logic signed [SUM_W-1:0]       s2_sum_ff;
   logic signed [FRAC_BITS+1:0]   s2_large_ff;
   logic [EXP_BITS-1:0]           s2_exp_ff;
   logic                          s2_bypass_ff;

   assign s2_en     = !s2_valid_ff || !hold_in;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign stall_out = !s1_en;

   always_comb begin
      sig_a_in   = signed'(SUM_W'({1'b1, frac_a}));
      pos_b      = signed'(SUM_W'({1'b1, frac_b}));
      sig_b_in   = action ? -pos_b : pos_b;
      a_small_in = exp_a < exp_b;
      diff_in    = a_small_in ? (exp_b - exp_a) : (exp_a - exp_b);
      big_exp_in = a_small_in ? exp_b : exp_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_sig_a_ff   <= sig_a_in;
         s1_sig_b_ff   <= sig_b_in;
         s1_a_small_ff <= a_small_in;
         s1_diff_ff    <= diff_in;
         s1_big_exp_ff <= big_exp_in;
      end
   end

   // A positive operand that is shifted past all of its bits becomes zero and
   // the other operand is passed on unchanged.
   always_comb begin
      small_sig   = s1_a_small_ff ? s1_sig_a_ff : s1_sig_b_ff;
      large_sig   = s1_a_small_ff ? s1_sig_b_ff : s1_sig_a_ff;
      shifted_sig = small_sig >>> s1_diff_ff;
      bypass_in   = (32'(s1_diff_ff) >= 32'(FRAC_BITS + 1)) && !small_sig[SUM_W-1];
      sum_in      = large_sig + shifted_sig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_sum_ff    <= sum_in;
         s2_large_ff  <= large_sig[FRAC_BITS+1:0];
         s2_exp_ff    <= s1_big_exp_ff;
         s2_bypass_ff <= bypass_in;
      end
   end

   assign ctrl_out.valid  = s2_valid_ff;
   assign ctrl_out.bypass = s2_bypass_ff;
   assign sum_out         = s2_sum_ff;
   assign large_out       = s2_large_ff;
   assign exp_out         = s2_exp_ff;

endmodule

[rtl/fas_normalize.sv]
// Right normalization, cancellation, overflow and underflow checks, leading-zero count.
module fas_normalize #(
   parameter int FRAC_BITS = fas_pkg::FRAC_BITS_DEFAULT,
   parameter int EXP_BITS  = fas_pkg::EXP_BITS_DEFAULT,
   parameter int SHIFT_W   = $clog2(FRAC_BITS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fas_pkg::align_ctrl_type       ctrl_in,
   input  logic signed [FRAC_BITS+2:0]   sum_in,
   input  logic signed [FRAC_BITS+1:0]   large_in,
   input  logic [EXP_BITS-1:0]           exp_in,
   output logic                          stall_out,
   input  logic                          hold_in,
   output fas_pkg::norm_ctrl_type        ctrl_out,
   output logic signed [FRAC_BITS+1:0]   mant_out,
   output logic signed [EXP_BITS+1:0]    exp_out,
   output logic [SHIFT_W-1:0]            shift_out
);

   localparam int SUM_W   = FRAC_BITS + 3;
   localparam int MANT_W  = FRAC_BITS + 2;
   localparam int EXP_O_W = EXP_BITS + 2;

   logic                       s3_en;
   logic                       s4_en;
   logic                       s3_valid_ff;
   logic                       s4_valid_ff;

   logic [SUM_W-1:0]           mag;
   logic signed [SUM_W-1:0]    halved;
   logic                       over;
   logic signed [MANT_W-1:0]   zs_in;
   logic [EXP_BITS:0]          ze_in;
   logic                       skip_in;
   fas_pkg::status_type        status3_in;

   logic signed [MANT_W-1:0]   s3_zs_ff;
   logic [EXP_BITS:0]          s3_ze_ff;
   logic [FRAC_BITS:0]         s3_mag_ff;
   logic                       s3_skip_ff;
   fas_pkg::status_type        s3_status_ff;

   int                         msb;
   logic [SHIFT_W-1:0]         lead;
   logic                       under;
   logic [SHIFT_W-1:0]         shift_in;
   logic signed [EXP_O_W-1:0]  exp4_in;
   fas_pkg::status_type        status4_in;

   logic signed [MANT_W-1:0]   s4_zs_ff;
   logic signed [EXP_O_W-1:0]  s4_exp_ff;
   logic [SHIFT_W-1:0]         s4_shift_ff;
   fas_pkg::status_type        s4_status_ff;

   assign s4_en     = !s4_valid_ff || !hold_in;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign stall_out = !s3_en;

   always_comb begin
      mag        = sum_in[SUM_W-1] ? unsigned'(-sum_in) : unsigned'(sum_in);
      halved     = sum_in >>> 1;
      over       = |mag[SUM_W-1:FRAC_BITS+1];
      zs_in      = sum_in[MANT_W-1:0];
      ze_in      = {1'b0, exp_in};
      skip_in    = 1'b0;
      status3_in = fas_pkg::STATUS_NORMAL;
      if (ctrl_in.bypass) begin
         zs_in   = large_in;
         skip_in = 1'b1;
      end else if (sum_in == '0) begin
         zs_in   = '0;
         ze_in   = '0;
         skip_in = 1'b1;
      end else if (over) begin
         zs_in   = halved[MANT_W-1:0];
         ze_in   = {1'b0, exp_in} + 1'b1;
         skip_in = 1'b1;
         if (exp_in == '1) begin
            status3_in = fas_pkg::STATUS_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_zs_ff     <= zs_in;
         s3_ze_ff     <= ze_in;
         s3_mag_ff    <= mag[FRAC_BITS:0];
         s3_skip_ff   <= skip_in;
         s3_status_ff <= status3_in;
      end
   end

   // The left shift stops early, at the first step that takes the exponent below zero.
   always_comb begin
      msb = 0;
      for (int i = 0; i <= FRAC_BITS; i++) begin
         if (s3_mag_ff[i]) begin
            msb = i;
         end
      end
      lead       = SHIFT_W'(FRAC_BITS - msb);
      under      = !s3_skip_ff && (32'(lead) > 32'(s3_ze_ff));
      shift_in   = lead;
      exp4_in    = signed'(EXP_O_W'(s3_ze_ff)) - signed'(EXP_O_W'(lead));
      status4_in = s3_status_ff;
      if (s3_skip_ff) begin
         shift_in = '0;
         exp4_in  = signed'(EXP_O_W'(s3_ze_ff));
      end else if (under) begin
         shift_in   = SHIFT_W'(s3_ze_ff) + 1'b1;
         exp4_in    = '1;
         status4_in = fas_pkg::STATUS_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_zs_ff     <= s3_zs_ff;
         s4_exp_ff    <= exp4_in;
         s4_shift_ff  <= shift_in;
         s4_status_ff <= status4_in;
      end
   end

   assign ctrl_out.valid  = s4_valid_ff;
   assign ctrl_out.status = s4_status_ff;
   assign mant_out        = s4_zs_ff;
   assign exp_out         = s4_exp_ff;
   assign shift_out       = s4_shift_ff;

endmodule

[rtl/float_add_subtract.sv]
// Top level of the pipelined floating-point adder/subtractor with its output stage.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   action, frac_a, exp_a, frac_b, exp_b
//   rsp_      out        rsp_valid / rsp_stall   signed_mant, exp_out, status
//
// A request is taken in every cycle in which req_stall is low. Its result passes
// through the five register stages in order: operand compare, alignment and add,
// right normalization, leading-zero count, left shift. Reset clears only the stage
// valid bits. Each stage holds while the stage after it is full and stalled, so empty
// stages still fill while the output waits.
module float_add_subtract #(
   parameter int FRAC_BITS = fas_pkg::FRAC_BITS_DEFAULT,
   parameter int EXP_BITS  = fas_pkg::EXP_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [FRAC_BITS-1:0]          req_frac_a,
   input  logic [EXP_BITS-1:0]           req_exp_a,
   input  logic [FRAC_BITS-1:0]          req_frac_b,
   input  logic [EXP_BITS-1:0]           req_exp_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [FRAC_BITS+1:0]   rsp_signed_mant,
   output logic signed [EXP_BITS+1:0]    rsp_exp_out,
   output logic [1:0]                    rsp_status
);

   localparam int SHIFT_W = $clog2(FRAC_BITS + 1);

   fas_pkg::align_ctrl_type       align_ctrl;
   logic signed [FRAC_BITS+2:0]   align_sum;
   logic signed [FRAC_BITS+1:0]   align_large;
   logic [EXP_BITS-1:0]           align_exp;
   logic                          norm_stall;

   fas_pkg::norm_ctrl_type        norm_ctrl;
   logic signed [FRAC_BITS+1:0]   norm_mant;
   logic signed [EXP_BITS+1:0]    norm_exp;
   logic [SHIFT_W-1:0]            norm_shift;

   logic                          out_en;
   logic                          rsp_valid_ff;
   logic signed [FRAC_BITS+1:0]   rsp_mant_ff;
   logic signed [EXP_BITS+1:0]    rsp_exp_ff;
   fas_pkg::status_type           rsp_status_ff;

   fas_align #(
      .FRAC_BITS (FRAC_BITS),
      .EXP_BITS  (EXP_BITS)
   ) u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .stall_out (req_stall),
      .action    (req_action),
      .frac_a    (req_frac_a),
      .exp_a     (req_exp_a),
      .frac_b    (req_frac_b),
      .exp_b     (req_exp_b),
      .hold_in   (norm_stall),
      .ctrl_out  (align_ctrl),
      .sum_out   (align_sum),
      .large_out (align_large),
      .exp_out   (align_exp)
   );

   fas_normalize #(
      .FRAC_BITS (FRAC_BITS),
      .EXP_BITS  (EXP_BITS),
      .SHIFT_W   (SHIFT_W)
   ) u_normalize (
      .clock     (clock),
      .reset     (reset),
      .ctrl_in   (align_ctrl),
      .sum_in    (align_sum),
      .large_in  (align_large),
      .exp_in    (align_exp),
      .stall_out (norm_stall),
      .hold_in   (!out_en),
      .ctrl_out  (norm_ctrl),
      .mant_out  (norm_mant),
      .exp_out   (norm_exp),
      .shift_out (norm_shift)
   );

   assign out_en = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= norm_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_mant_ff   <= norm_mant <<< norm_shift;
         rsp_exp_ff    <= norm_exp;
         rsp_status_ff <= norm_ctrl.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_signed_mant = rsp_mant_ff;
   assign rsp_exp_out     = rsp_exp_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[verif/float_add_subtract_tb.sv]
// Self-checking testbench for the float_add_subtract pipeline with random request and stall timing.
`timescale 1ns / 100ps

module float_add_subtract_tb;

   localparam int FW = fas_pkg::FRAC_BITS_DEFAULT;
   localparam int EW = fas_pkg::EXP_BITS_DEFAULT;
   localparam int MW = FW + 2;
   localparam int XW = EW + 2;
   localparam longint MAX_SIG = (longint'(1) << (FW + 1)) - 1;
   localparam longint MIN_SIG = longint'(1) << FW;
   localparam longint EXP_LIMIT = longint'(1) << EW;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic signed [FW+1:0] mant;
      logic signed [EW+1:0] expo;
      fas_pkg::status_type  status;
   } sum_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_action;
   logic [FW-1:0]        req_frac_a;
   logic [EW-1:0]        req_exp_a;
   logic [FW-1:0]        req_frac_b;
   logic [EW-1:0]        req_exp_b;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [FW+1:0] rsp_signed_mant;
   logic signed [EW+1:0] rsp_exp_out;
   logic [1:0]           rsp_status;

   sum_result_type sums_pending[$];
   sum_result_type sum_wanted;
   int             mismatch_count = 0;
   bit             steady = 1'b0;
   bit             hold_request = 1'b0;

   float_add_subtract #(
      .FRAC_BITS(FW),
      .EXP_BITS(EW)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_frac_a(req_frac_a),
      .req_exp_a(req_exp_a),
      .req_frac_b(req_frac_b),
      .req_exp_b(req_exp_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_signed_mant(rsp_signed_mant),
      .rsp_exp_out(rsp_exp_out),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("float_add_subtract_tb failed");
      $finish;
   end

   function automatic longint shift_floor(input longint v, input longint d);
      if (d >= 63) begin
         return (v < 0) ? -1 : 0;
      end
      return v >>> d;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic sum_result_type predict_sum(input logic op, input logic [FW-1:0] fa,
                                                  input logic [EW-1:0] ea,
                                                  input logic [FW-1:0] fb,
                                                  input logic [EW-1:0] eb);
      longint         sig_a;
      longint         sig_b;
      longint         xe;
      longint         ye;
      longint         total;
      longint         texp;
      int             steps;
      sum_result_type r;
      sig_a = longint'({1'b1, fa});
      sig_b = longint'({1'b1, fb});
      xe = longint'(ea);
      ye = longint'(eb);
      r.status = fas_pkg::STATUS_NORMAL;
      if (op) begin
         sig_b = -sig_b;
      end
      if (xe < ye) begin
         sig_a = shift_floor(sig_a, ye - xe);
         if (sig_a == 0) begin
            r.mant = MW'(sig_b);
            r.expo = XW'(ye);
            return r;
         end
         xe = ye;
      end else if (ye < xe) begin
         sig_b = shift_floor(sig_b, xe - ye);
         if (sig_b == 0) begin
            r.mant = MW'(sig_a);
            r.expo = XW'(xe);
            return r;
         end
      end
      total = sig_a + sig_b;
      texp = xe;
      if (total == 0) begin
         r.mant = '0;
         r.expo = '0;
         return r;
      end
      while (magnitude(total) > MAX_SIG) begin
         total = shift_floor(total, 1);
         texp = texp + 1;
         if (texp >= EXP_LIMIT) begin
            r.mant = MW'(total);
            r.expo = XW'(texp);
            r.status = fas_pkg::STATUS_OVERFLOW;
            return r;
         end
      end
      for (steps = 0; steps <= FW && magnitude(total) < MIN_SIG; steps++) begin
         total = total * 2;
         texp = texp - 1;
         if (texp < 0) begin
            r.mant = MW'(total);
            r.expo = XW'(texp);
            r.status = fas_pkg::STATUS_UNDERFLOW;
            return r;
         end
      end
      r.mant = MW'(total);
      r.expo = XW'(texp);
      return r;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(20, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic send_request(input logic op, input logic [FW-1:0] fa, input logic [EW-1:0] ea,
                               input logic [FW-1:0] fb, input logic [EW-1:0] eb);
      req_valid <= 1'b1;
      req_action <= op;
      req_frac_a <= fa;
      req_exp_a <= ea;
      req_frac_b <= fb;
      req_exp_b <= eb;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      sums_pending.push_back(predict_sum(op, fa, ea, fb, eb));
      if (!steady && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sums_pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_request();
      int             kind;
      logic           op;
      logic [FW-1:0]  fa;
      logic [FW-1:0]  fb;
      logic [EW-1:0]  ea;
      logic [EW-1:0]  eb;
      kind = $urandom_range(0, 11);
      op = 1'($urandom_range(0, 1));
      fa = FW'($urandom);
      fb = FW'($urandom);
      ea = EW'($urandom);
      eb = EW'($urandom);
      case (kind)
         0, 1: begin
            eb = ea;
         end
         2: begin
            eb = ea;
            fb = fa ^ (FW'(1) << $urandom_range(0, FW - 1));
            op = 1'b1;
         end
         3: begin
            eb = ea;
            fb = fa;
            op = 1'b1;
         end
         4, 5: begin
            eb = ea + EW'($urandom_range(0, 3));
         end
         6: begin
            ea = EW'($urandom_range(0, 3));
            eb = ea + EW'($urandom_range(0, 1));
            op = 1'b1;
         end
         7: begin
            ea = EW'($urandom_range(250, 255));
            eb = EW'($urandom_range(250, 255));
            op = 1'b0;
         end
         8: begin
            eb = ea - EW'($urandom_range(20, 30));
         end
         default: begin
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         send_request(op, fa, ea, fb, eb);
      end else begin
         send_request(op, fb, eb, fa, ea);
      end
   endtask

   task automatic test_directed_cases();
      send_request(1'b0, '0, '0, '0, '0);
      send_request(1'b1, '0, '0, '0, '0);
      send_request(1'b0, '1, '1, '1, '1);
      send_request(1'b1, '1, '1, '1, '1);
      send_request(1'b0, '1, 8'd254, '0, 8'd254);
      send_request(1'b0, '0, 8'd254, '1, 8'd253);
      send_request(1'b1, 23'd1, '0, '0, '0);
      send_request(1'b1, '0, '0, '1, '0);
      send_request(1'b1, 23'd1, 8'd100, '0, 8'd100);
      send_request(1'b0, '1, '0, 23'h2AAAAA, 8'd100);
      send_request(1'b0, 23'h555555, 8'd200, '1, 8'd10);
      send_request(1'b1, '0, 8'd200, '1, '0);
      send_request(1'b1, '0, 8'd100, '0, '0);
      send_request(1'b1, '1, '0, '0, 8'd200);
      send_request(1'b0, '1, '0, '0, 8'd23);
      send_request(1'b0, '1, '0, '0, 8'd24);
      send_request(1'b0, '0, 8'd24, '1, '0);
      send_request(1'b1, '0, 8'd24, '1, '0);
      send_request(1'b1, 23'h2AAAAA, 8'd77, 23'h555555, 8'd76);
      send_request(1'b0, 23'h555555, '1, 23'h2AAAAA, '0);
      send_request(1'b1, '1, 8'd1, '1, 8'd1);
      send_request(1'b1, 23'h400000, 8'd5, '1, 8'd4);
      wait_for_results();
   endtask

   task automatic test_random_operands(input int count);
      repeat (count) random_request();
      wait_for_results();
   endtask

   task automatic test_back_to_back(input int count);
      steady = 1'b1;
      repeat (count) random_request();
      steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_output_hold(input int count);
      hold_request = 1'b1;
      steady = 1'b1;
      repeat (count) random_request();
      steady = 1'b0;
      wait_for_results();
   endtask

   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!steady && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_length()) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (sums_pending.size() == 0) begin
            report_mismatch($sformatf("result with no request waiting: mant %0d exp %0d status %0d",
                                      rsp_signed_mant, rsp_exp_out, rsp_status));
         end else begin
            sum_wanted = sums_pending.pop_front();
            if (rsp_signed_mant !== sum_wanted.mant || rsp_exp_out !== sum_wanted.expo ||
                rsp_status !== sum_wanted.status) begin
               report_mismatch($sformatf("got mant %0d exp %0d status %0d, wanted %0d %0d %0d",
                                         rsp_signed_mant, rsp_exp_out, rsp_status,
                                         sum_wanted.mant, sum_wanted.expo, sum_wanted.status));
            end
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_action = 1'b0;
      req_frac_a = '0;
      req_exp_a = '0;
      req_frac_b = '0;
      req_exp_b = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_operands(1000);
      test_back_to_back(60);
      test_output_hold(40);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && sums_pending.size() == 0) begin
         $display("float_add_subtract_tb passed");
      end else begin
         $display("float_add_subtract_tb failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/fas_pkg.sv
rtl/fas_align.sv
rtl/fas_normalize.sv
rtl/float_add_subtract.sv
verif/float_add_subtract_tb.sv
